// ===== hw/rtl/sqvt_pkg.sv =====
package sqvt_pkg;

   localparam int DefaultSineEntries = 1024;
   localparam int SineLatency = 4;

   localparam int PolyA = 102943;
   localparam int PolyB = 42047;
   localparam int PolyC = 4640;

   localparam int OffsetWidth = 31;
   localparam int WaveWidth = 18;

   typedef struct packed {
      logic [1:0]                    corner;
      logic signed [OffsetWidth-1:0] ox;
      logic signed [OffsetWidth-1:0] oy;
      logic [15:0]                   sx;
      logic [15:0]                   sy;
      logic signed [23:0]            px;
      logic signed [23:0]            py;
      logic                          rot_zero;
   } corner_type;

endpackage

// ===== hw/rtl/sqvt_issue.sv =====
module sqvt_issue #(
   parameter int SINE_TABLE_ENTRIES = sqvt_pkg::DefaultSineEntries
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [11:0]            req_sprite_width,
   input  logic [11:0]            req_sprite_height,
   input  logic [16:0]            req_pivot_x,
   input  logic [16:0]            req_pivot_y,
   input  logic [15:0]            req_scale_x,
   input  logic [15:0]            req_scale_y,
   input  logic [15:0]            req_rotation,
   input  logic signed [23:0]     req_pos_x,
   input  logic signed [23:0]     req_pos_y,
   input  logic                   en,
   output logic                   out_valid,
   output sqvt_pkg::corner_type   out_pay,
   output logic [15:0]            out_phase
);

   localparam int Shift = 16 - $clog2(SINE_TABLE_ENTRIES);
   localparam logic [15:0] PhaseMask = 16'(32'hFFFF << Shift);

   logic               hold_v_ff, hold_v_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [11:0]        w_ff, h_ff;
   logic [16:0]        pvx_ff, pvy_ff;
   logic [15:0]        sx_ff, sy_ff, rot_ff;
   logic signed [23:0] px_ff, py_ff;

   logic                   ov_ff;
   sqvt_pkg::corner_type   pay_ff, pay_in;
   logic [15:0]            phase_ff;

   logic                   acc, take;
   logic [28:0]            ox0;
   logic signed [17:0]     dy;
   logic signed [30:0]     oy0;
   logic [27:0]            wsh, hsh;

   assign take = hold_v_ff && en;
   assign req_ready = !hold_v_ff || (en && cnt_ff == 2'd3);
   assign acc = req_valid && req_ready;

   always_comb begin
      hold_v_in = hold_v_ff;
      cnt_in = cnt_ff;
      priority if (acc) begin
         hold_v_in = 1'b1;
         cnt_in = 2'd0;
      end else if (take) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            hold_v_in = 1'b0;
         end
      end
   end

   always_comb begin
      ox0 = 29'(w_ff) * 29'(pvx_ff);
      dy = 18'sd65536 - $signed({1'b0, pvy_ff});
      oy0 = 31'($signed({1'b0, h_ff})) * 31'(dy);
      wsh = {w_ff, 16'h0000};
      hsh = {h_ff, 16'h0000};
      pay_in.corner = cnt_ff;
      pay_in.ox = cnt_ff[0] ? $signed({2'b00, ox0}) - $signed({3'b000, wsh})
                            : $signed({2'b00, ox0});
      pay_in.oy = cnt_ff[1] ? oy0 - $signed({3'b000, hsh}) : oy0;
      pay_in.sx = sx_ff;
      pay_in.sy = sy_ff;
      pay_in.px = px_ff;
      pay_in.py = py_ff;
      pay_in.rot_zero = (rot_ff == 16'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         cnt_ff <= 2'd0;
         ov_ff <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         cnt_ff <= cnt_in;
         if (en) begin
            ov_ff <= hold_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         w_ff <= req_sprite_width;
         h_ff <= req_sprite_height;
         pvx_ff <= req_pivot_x;
         pvy_ff <= req_pivot_y;
         sx_ff <= req_scale_x;
         sy_ff <= req_scale_y;
         rot_ff <= req_rotation;
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
      end
      if (en) begin
         pay_ff <= pay_in;
         phase_ff <= rot_ff & PhaseMask;
      end
   end

   assign out_valid = ov_ff;
   assign out_pay = pay_ff;
   assign out_phase = phase_ff;

endmodule

// ===== hw/rtl/sqvt_sine.sv =====
module sqvt_sine (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [15:0]                          phase,
   output logic signed [sqvt_pkg::WaveWidth-1:0] wave
);

   logic [14:0] g;
   logic [16:0] z;
   logic [33:0] zz;

   logic [16:0] z1_ff, z21_ff;
   logic        n1_ff;
   logic [29:0] tp;
   logic [15:0] inner;

   logic [16:0] z2_ff, z22_ff;
   logic [15:0] in2_ff;
   logic        n2_ff;
   logic [32:0] up;
   logic [16:0] mid;

   logic [16:0] z3_ff, mid3_ff;
   logic        n3_ff;
   logic [33:0] rp;
   logic [16:0] v;

   logic signed [sqvt_pkg::WaveWidth-1:0] wave_ff, wave_in;

   always_comb begin
      g = phase[14] ? 15'd16384 - {1'b0, phase[13:0]} : {1'b0, phase[13:0]};
      z = {g, 2'b00};
      zz = 34'(z) * 34'(z);
      tp = 30'(z21_ff) * 30'(sqvt_pkg::PolyC);
      inner = 16'(sqvt_pkg::PolyB) - {3'b000, tp[28:16]};
      up = 33'(z22_ff) * 33'(in2_ff);
      mid = 17'(sqvt_pkg::PolyA) - {1'b0, up[31:16]};
      rp = 34'(z3_ff) * 34'(mid3_ff);
      v = (rp[33:16] > 18'd65536) ? 17'd65536 : rp[32:16];
      wave_in = n3_ff ? -$signed({1'b0, v}) : $signed({1'b0, v});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z1_ff <= z;
         z21_ff <= zz[32:16];
         n1_ff <= phase[15];
         z2_ff <= z1_ff;
         z22_ff <= z21_ff;
         in2_ff <= inner;
         n2_ff <= n1_ff;
         z3_ff <= z2_ff;
         mid3_ff <= mid;
         n3_ff <= n2_ff;
         wave_ff <= wave_in;
      end
   end

   assign wave = wave_ff;

endmodule

// ===== hw/rtl/sqvt_xform.sv =====
module sqvt_xform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  sqvt_pkg::corner_type                 in_pay,
   input  logic signed [sqvt_pkg::WaveWidth-1:0] c,
   input  logic signed [sqvt_pkg::WaveWidth-1:0] s,
   output logic                                 out_valid,
   output logic [1:0]                           out_corner,
   output logic signed [31:0]                   out_x,
   output logic signed [31:0]                   out_y,
   output logic                                 out_clipped,
   output logic                                 out_last
);

   localparam int ProdWidth = sqvt_pkg::WaveWidth + sqvt_pkg::OffsetWidth;

   logic [4:0] v_ff;
   sqvt_pkg::corner_type p1_ff, p2_ff, p3_ff, p4_ff;

   logic signed [ProdWidth-1:0] cox_ff, soy_ff, coy_ff, sox_ff;
   logic signed [49:0]          sumx_ff, sumy_ff;
   logic [39:0]                 plx_ff, ply_ff;
   logic signed [42:0]          phx_ff, phy_ff;
   logic signed [33:0]          vx_ff, vy_ff, vx_in, vy_in;
   logic signed [65:0]          prx, pry;
   logic signed [34:0]          ax, ay;
   logic signed [31:0]          x_ff, y_ff, x_in, y_in;
   logic                        clip_ff, clip_in;
   logic [1:0]                  k_ff;

   always_comb begin
      prx = (66'(phx_ff) <<< 24) + $signed({26'd0, plx_ff}) + (66'sd1 <<< 31);
      pry = (66'(phy_ff) <<< 24) + $signed({26'd0, ply_ff}) + (66'sd1 <<< 31);
      vx_in = prx[65:32];
      vy_in = pry[65:32];
      ax = 35'(vx_ff) + 35'(p4_ff.px);
      ay = 35'(vy_ff) + 35'(p4_ff.py);
      clip_in = 1'b0;
      x_in = ax[31:0];
      y_in = ay[31:0];
      if (ax > 35'sd2147483647) begin
         x_in = 32'sh7FFFFFFF;
         clip_in = 1'b1;
      end else if (ax < -35'sd2147483648) begin
         x_in = 32'sh80000000;
         clip_in = 1'b1;
      end
      if (ay > 35'sd2147483647) begin
         y_in = 32'sh7FFFFFFF;
         clip_in = 1'b1;
      end else if (ay < -35'sd2147483648) begin
         y_in = 32'sh80000000;
         clip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cox_ff <= ProdWidth'(c) * ProdWidth'(in_pay.ox);
         soy_ff <= ProdWidth'(s) * ProdWidth'(in_pay.oy);
         coy_ff <= ProdWidth'(c) * ProdWidth'(in_pay.oy);
         sox_ff <= ProdWidth'(s) * ProdWidth'(in_pay.ox);
         p1_ff <= in_pay;
         sumx_ff <= 50'(cox_ff) + 50'(soy_ff);
         sumy_ff <= 50'(coy_ff) - 50'(sox_ff);
         p2_ff <= p1_ff;
         plx_ff <= 40'(p2_ff.sx) * 40'(sumx_ff[23:0]);
         ply_ff <= 40'(p2_ff.sy) * 40'(sumy_ff[23:0]);
         phx_ff <= 43'($signed(sumx_ff[49:24])) * 43'($signed({1'b0, p2_ff.sx}));
         phy_ff <= 43'($signed(sumy_ff[49:24])) * 43'($signed({1'b0, p2_ff.sy}));
         p3_ff <= p2_ff;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         p4_ff <= p3_ff;
         x_ff <= x_in;
         y_ff <= y_in;
         clip_ff <= clip_in;
         k_ff <= p4_ff.corner;
      end
   end

   assign out_valid = v_ff[4];
   assign out_corner = k_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_clipped = clip_ff;
   assign out_last = (k_ff == 2'd3);

endmodule

// ===== hw/rtl/sprite_quad_vertex_transform_unit.sv =====
// Sprite quad vertex transform.
// Request channel (req_*): one sprite per transfer with size, pivot, scale,
// rotation and position. Response channel (rsp_*): four corner transfers per
// sprite in strip order, corner 3 flagged by rsp_last_corner; each coordinate
// saturates to 32 bits and rsp_clipped reports it.
// Throughput: one corner per cycle unless rsp_ready stalls the pipeline; the
// request side holds one sprite and issues a corner per cycle into the pipeline.
// The first corner passes one issue stage, four stages of sine/cosine
// polynomial and five stages of rotate, scale, round and translate. A new
// sprite is taken in the cycle its last corner issues.
// SINE_TABLE_ENTRIES must be a power of two; it quantizes the rotation angle.
// Reset clears all valid bits, dropping the held sprite; no data register is reset.
// When rsp_ready is low with a corner waiting, the whole pipeline holds and
// the request side takes a new sprite only if none is held; nothing is dropped or repeated.
module sprite_quad_vertex_transform_unit #(
   parameter int SINE_TABLE_ENTRIES = sqvt_pkg::DefaultSineEntries
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [11:0]        req_sprite_width,
   input  logic [11:0]        req_sprite_height,
   input  logic [16:0]        req_pivot_x,
   input  logic [16:0]        req_pivot_y,
   input  logic [15:0]        req_scale_x,
   input  logic [15:0]        req_scale_y,
   input  logic [15:0]        req_rotation,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_corner_index,
   output logic signed [31:0] rsp_vert_x,
   output logic signed [31:0] rsp_vert_y,
   output logic               rsp_clipped,
   output logic               rsp_last_corner
);

   localparam int Lat = sqvt_pkg::SineLatency;

   logic                 en;
   logic                 iss_valid;
   sqvt_pkg::corner_type iss_pay;
   logic [15:0]          iss_phase;
   logic [15:0]          cos_phase;

   logic signed [sqvt_pkg::WaveWidth-1:0] sin_w, cos_w, c_sel, s_sel;

   logic                 dv_ff [Lat];
   sqvt_pkg::corner_type dp_ff [Lat];

   assign en = !rsp_valid || rsp_ready;
   assign cos_phase = iss_phase + 16'd16384;

   sqvt_issue #(
      .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
   ) u_issue (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sprite_width(req_sprite_width),
      .req_sprite_height(req_sprite_height),
      .req_pivot_x(req_pivot_x),
      .req_pivot_y(req_pivot_y),
      .req_scale_x(req_scale_x),
      .req_scale_y(req_scale_y),
      .req_rotation(req_rotation),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .en(en),
      .out_valid(iss_valid),
      .out_pay(iss_pay),
      .out_phase(iss_phase)
   );

   sqvt_sine u_sin (
      .clock(clock),
      .en(en),
      .phase(iss_phase),
      .wave(sin_w)
   );

   sqvt_sine u_cos (
      .clock(clock),
      .en(en),
      .phase(cos_phase),
      .wave(cos_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lat; i++) begin
            dv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         dv_ff[0] <= iss_valid;
         for (int i = 1; i < Lat; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp_ff[0] <= iss_pay;
         for (int i = 1; i < Lat; i++) begin
            dp_ff[i] <= dp_ff[i-1];
         end
      end
   end

   assign c_sel = dp_ff[Lat-1].rot_zero ? 18'sd65536 : cos_w;
   assign s_sel = dp_ff[Lat-1].rot_zero ? 18'sd0 : sin_w;

   sqvt_xform u_xform (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(dv_ff[Lat-1]),
      .in_pay(dp_ff[Lat-1]),
      .c(c_sel),
      .s(s_sel),
      .out_valid(rsp_valid),
      .out_corner(rsp_corner_index),
      .out_x(rsp_vert_x),
      .out_y(rsp_vert_y),
      .out_clipped(rsp_clipped),
      .out_last(rsp_last_corner)
   );

`ifndef ASSERT_OFF
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_corner == (rsp_corner_index == 2'd3)))
      else $error("last corner flag mismatch");

   a_issue_hold: assert property (@(posedge clock) disable iff (reset)
      iss_valid && !en |=> iss_valid)
      else $error("issued corner lost during stall");

   a_one_sprite: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sprite taken before corners issued");
`endif

endmodule
